// File: rtl/recursive_sine_oscillator_bank_top_macros.svh
// assertion macros shared by the oscillator bank modules
`ifndef RECURSIVE_SINE_OSCILLATOR_BANK_TOP_MACROS_SVH
`define RECURSIVE_SINE_OSCILLATOR_BANK_TOP_MACROS_SVH

// property holds at every clock edge outside reset
`define RSOB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// consequent holds in the cycle after the trigger
`define RSOB_ASSERT_NEXT(lbl, clk, rst_n, trig, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/rsob_pkg.sv
// shared types, constants and saturation helper of the oscillator bank
package rsob_pkg;

    localparam int Q_W     = 24;
    localparam int GAIN_W  = 16;
    localparam int IDX_W   = 7;
    localparam int PROD_W  = 2 * Q_W;
    localparam int GPROD_W = Q_W + GAIN_W;
    localparam int ROUND_Q = 22;
    localparam int ROUND_G = 15;
    localparam int RND_W   = PROD_W - ROUND_Q;
    localparam int DIFF_W  = RND_W + 1;
    localparam int TERM_W  = GPROD_W - ROUND_G;

    localparam logic signed [31:0] Q_MAX = 32'sd8388607;
    localparam logic signed [31:0] Q_MIN = -32'sd8388608;

    localparam logic signed [PROD_W-1:0]  RND_Q = 48'sd2097152;
    localparam logic signed [GPROD_W-1:0] RND_G = 40'sd16384;

    // request codes
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef struct packed {
        logic signed [Q_W-1:0]    coeff;
        logic signed [Q_W-1:0]    prev;
        logic signed [Q_W-1:0]    cur;
        logic signed [GAIN_W-1:0] gain;
    } t_osc_word;

    typedef struct packed {
        logic clear_we;
        logic load_req;
        logic issue;
        logic acc_clr;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic pipe_busy;
    } t_dp_sts;

    typedef struct packed {
        logic signed [Q_W-1:0] value;
        logic                  hit;
    } t_sat;

    function automatic t_sat sat_q(input logic signed [31:0] v);
        t_sat r;
        r.hit = 1'b1;
        if (v > Q_MAX) begin
            r.value = Q_MAX[Q_W-1:0];
        end else if (v < Q_MIN) begin
            r.value = Q_MIN[Q_W-1:0];
        end else begin
            r.value = v[Q_W-1:0];
            r.hit   = 1'b0;
        end
        return r;
    endfunction

endpackage

// File: rtl/rsob_ram.sv
// generic single write, single read ram with registered read data
module rsob_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/rsob_datapath.sv
// oscillator store, step and gain pipeline, accumulator and output register
module rsob_datapath import rsob_pkg::*; #(
    parameter int NUM_OSC = 128,
    localparam int AW = (NUM_OSC > 1) ? $clog2(NUM_OSC) : 1
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_cmd                  i_cmd,
    input  logic [AW-1:0]            i_addr,
    input  logic [IDX_W-1:0]         i_osc_index,
    input  logic signed [Q_W-1:0]    i_coeff_k,
    input  logic signed [Q_W-1:0]    i_init_prev,
    input  logic signed [GAIN_W-1:0] i_gain_value,
    output t_dp_sts                  o_sts,
    output logic signed [Q_W-1:0]    o_sample,
    output logic                     o_clipped
);

`include "recursive_sine_oscillator_bank_top_macros.svh"

    localparam int SHIFT  = $clog2(NUM_OSC);
    localparam int ACC_W  = TERM_W + SHIFT + 1;
    localparam int WORD_W = $bits(t_osc_word);

    // ram ports
    logic              w_we;
    logic [AW-1:0]     w_waddr;
    logic [WORD_W-1:0] w_wdata;
    logic [WORD_W-1:0] w_rdata;

    // pipeline registers
    logic                      r_v_rd, r_v_mul, r_v_o, r_v_g;
    logic [AW-1:0]             r_a_rd, r_a_mul, r_a_o;
    t_osc_word                 r_w1, r_w2;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [Q_W-1:0]     r_o;
    logic signed [GPROD_W-1:0] r_gprod;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [Q_W-1:0]     r_sample;
    logic                      r_clipped;

    // combinational values
    logic                      n_load_ok;
    t_osc_word                 n_load_word;
    t_osc_word                 n_wb_word;
    t_osc_word                 n_rd;
    logic signed [PROD_W-1:0]  n_prod;
    logic signed [PROD_W-1:0]  n_sum;
    logic signed [RND_W-1:0]   n_rnd;
    logic signed [DIFF_W-1:0]  n_diff;
    t_sat                      n_step;
    logic signed [GPROD_W-1:0] n_gprod;
    logic signed [GPROD_W-1:0] n_gsum;
    logic signed [TERM_W-1:0]  n_term;
    logic signed [ACC_W-1:0]   n_acc;
    logic signed [ACC_W-SHIFT-1:0] n_norm;
    t_sat                      n_out;

    rsob_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NUM_OSC)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (i_cmd.issue),
        .i_raddr (i_addr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        // out of range loads are dropped
        n_load_ok         = i_cmd.load_req && (32'(i_osc_index) < NUM_OSC);
        n_load_word.coeff = i_coeff_k;
        n_load_word.prev  = i_init_prev;
        n_load_word.cur   = '0;
        n_load_word.gain  = i_gain_value;

        n_wb_word.coeff = r_w2.coeff;
        n_wb_word.prev  = r_w2.cur;
        n_wb_word.cur   = r_o;
        n_wb_word.gain  = r_w2.gain;

        w_we    = 1'b0;
        w_waddr = i_addr;
        w_wdata = '0;
        if (i_cmd.clear_we) begin
            w_we = 1'b1;
        end else if (n_load_ok) begin
            w_we    = 1'b1;
            w_waddr = AW'(i_osc_index);
            w_wdata = n_load_word;
        end else if (r_v_o) begin
            w_we    = 1'b1;
            w_waddr = r_a_o;
            w_wdata = n_wb_word;
        end
    end

    always_comb begin
        n_rd    = t_osc_word'(w_rdata);
        n_prod  = n_rd.coeff * n_rd.cur;
        // round half up to q2.22, then subtract prev
        n_sum   = r_prod + RND_Q;
        n_rnd   = n_sum[PROD_W-1:ROUND_Q];
        n_diff  = n_rnd - r_w1.prev;
        n_step  = sat_q(32'(n_diff));
        n_gprod = r_w2.gain * r_o;
        n_gsum  = r_gprod + RND_G;
        n_term  = n_gsum[GPROD_W-1:ROUND_G];
        n_acc   = r_acc + ACC_W'(n_term);
        n_norm  = r_acc[ACC_W-1:SHIFT];
        n_out   = sat_q(32'(n_norm));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_rd  <= 1'b0;
            r_v_mul <= 1'b0;
            r_v_o   <= 1'b0;
            r_v_g   <= 1'b0;
        end else begin
            r_v_rd  <= i_cmd.issue;
            r_v_mul <= r_v_rd;
            r_v_o   <= r_v_mul;
            r_v_g   <= r_v_o;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_rd <= i_addr;
        if (r_v_rd) begin
            r_w1    <= n_rd;
            r_prod  <= n_prod;
            r_a_mul <= r_a_rd;
        end
        if (r_v_mul) begin
            r_w2  <= r_w1;
            r_o   <= n_step.value;
            r_a_o <= r_a_mul;
        end
        if (r_v_o) begin
            r_gprod <= n_gprod;
        end
        if (i_cmd.acc_clr) begin
            r_acc <= '0;
        end else if (r_v_g) begin
            r_acc <= n_acc;
        end
        if (i_cmd.out_load) begin
            r_sample  <= n_out.value;
            r_clipped <= n_out.hit;
        end
    end

    assign o_sts.pipe_busy = r_v_rd | r_v_mul | r_v_o | r_v_g;
    assign o_sample        = r_sample;
    assign o_clipped       = r_clipped;

    `RSOB_ASSERT(a_one_write_source, i_clk, i_rst_n,
        ($onehot0({i_cmd.clear_we, i_cmd.load_req, r_v_o})),
        "two sources drive the store write port")
    `RSOB_ASSERT(a_acc_clr_when_empty, i_clk, i_rst_n,
        (i_cmd.acc_clr |-> !o_sts.pipe_busy),
        "accumulator cleared while pipeline holds oscillators")
    `RSOB_ASSERT(a_out_load_when_empty, i_clk, i_rst_n,
        (i_cmd.out_load |-> !o_sts.pipe_busy),
        "sample taken before the pipeline drained")

endmodule

// File: rtl/rsob_ctrl.sv
// sequencer for store clearing, loads and tick sweeps
module rsob_ctrl import rsob_pkg::*; #(
    parameter int NUM_OSC = 128,
    localparam int AW = (NUM_OSC > 1) ? $clog2(NUM_OSC) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_req_type,
    input  logic          i_out_ready,
    input  t_dp_sts       i_sts,
    output logic          o_in_ready,
    output logic          o_out_valid,
    output t_dp_cmd       o_cmd,
    output logic [AW-1:0] o_addr
);

`include "recursive_sine_oscillator_bank_top_macros.svh"

    localparam logic [AW-1:0] LAST = AW'(NUM_OSC - 1);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_ISSUE,
        S_DRAIN
    } t_state;

    t_state        r_state, n_state;
    logic [AW-1:0] r_cnt, n_cnt;
    logic          r_out_valid, n_out_valid;
    logic          n_accept;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        o_cmd       = '0;
        n_accept    = i_in_valid && (r_state == S_IDLE);
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear_we = 1'b1;
                if (r_cnt == LAST) begin
                    n_state = S_IDLE;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_IDLE: begin
                if (n_accept) begin
                    if (i_req_type == REQ_TICK) begin
                        o_cmd.acc_clr = 1'b1;
                        n_state       = S_ISSUE;
                        n_cnt         = '0;
                    end else begin
                        o_cmd.load_req = 1'b1;
                    end
                end
            end
            S_ISSUE: begin
                o_cmd.issue = 1'b1;
                if (r_cnt == LAST) begin
                    n_state = S_DRAIN;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_DRAIN: begin
                if (!i_sts.pipe_busy && (!r_out_valid || i_out_ready)) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_addr      = r_cnt;

    `RSOB_ASSERT(a_out_slot_free, i_clk, i_rst_n,
        (o_cmd.out_load |-> (!r_out_valid || i_out_ready)),
        "new sample would overwrite one not yet taken")
    `RSOB_ASSERT_NEXT(a_tick_starts_sweep, i_clk, i_rst_n,
        (i_in_valid && o_in_ready && i_req_type == REQ_TICK),
        (r_state == S_ISSUE && r_cnt == '0),
        "tick did not start the sweep at oscillator zero")
    `RSOB_ASSERT(a_idle_pipe_empty, i_clk, i_rst_n,
        ((r_state == S_IDLE) |-> !i_sts.pipe_busy),
        "pipeline busy while the sequencer is idle")

endmodule

// File: rtl/recursive_sine_oscillator_bank_top.sv
// top level of the recursive sine oscillator bank
//
//  channel  | handshake             | payload
//  ---------+-----------------------+---------------------------------------------
//  in       | i_in_valid/o_in_ready | i_req_type i_osc_index i_coeff_k
//           |                       | i_init_prev i_gain_value
//  out      | o_out_valid/i_out_ready | o_sample o_clipped
//
// a load beat is written to the store in the same cycle that it is accepted
// a tick beat makes one store read per cycle, which feeds a four stage pipeline
// (k*cur, round and subtract, gain multiply, accumulate)
// after reset the store is swept to zero, input not ready
// the finished sample sits in an output register, so the next beat is taken
// while it waits; a tick that finishes before the previous sample is taken holds
// in drain until the output register frees up
module recursive_sine_oscillator_bank_top import rsob_pkg::*; #(
    parameter int NUM_OSC = 128
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // request channel
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic                     i_req_type,
    input  logic [IDX_W-1:0]         i_osc_index,
    input  logic signed [Q_W-1:0]    i_coeff_k,
    input  logic signed [Q_W-1:0]    i_init_prev,
    input  logic signed [GAIN_W-1:0] i_gain_value,
    // sample channel
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [Q_W-1:0]    o_sample,
    output logic                     o_clipped
);

    localparam int AW = (NUM_OSC > 1) ? $clog2(NUM_OSC) : 1;

    // commands and status between sequencer and datapath
    t_dp_cmd       w_cmd;
    t_dp_sts       w_sts;
    logic [AW-1:0] w_addr;

    // sequencer: clear sweep, load strobe, tick sweep and drain
    rsob_ctrl #(
        .NUM_OSC (NUM_OSC)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_req_type  (i_req_type),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd),
        .o_addr      (w_addr)
    );

    // store, one shared step unit, gain multiply and accumulator
    rsob_datapath #(
        .NUM_OSC (NUM_OSC)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_addr       (w_addr),
        .i_osc_index  (i_osc_index),
        .i_coeff_k    (i_coeff_k),
        .i_init_prev  (i_init_prev),
        .i_gain_value (i_gain_value),
        .o_sts        (w_sts),
        .o_sample     (o_sample),
        .o_clipped    (o_clipped)
    );

endmodule

// File: test/tb_recursive_sine_oscillator_bank_top.sv
// testbench of the oscillator bank: directed rows, then random phrases checked by a bank model
module tb_recursive_sine_oscillator_bank_top import rsob_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    // bank size and the normalizing shift that follows from it
    localparam int NUM_OSC = 128;
    localparam int NORM_SH = $clog2(NUM_OSC);

    // run shape
    localparam int N_ITEMS     = 1900;
    localparam int CALM_ITEMS  = 200;       // last beats go without any idling
    localparam int STALL_LIMIT = 4000;      // cycles with no beat on either side
    localparam int TAIL_CYCLES = 2 * NUM_OSC + 20;

    // field extremes
    localparam logic signed [Q_W-1:0]    K_MAX = Q_MAX[Q_W-1:0];
    localparam logic signed [Q_W-1:0]    K_MIN = Q_MIN[Q_W-1:0];
    localparam logic signed [GAIN_W-1:0] G_MAX = 16'sh7FFF;
    localparam logic signed [GAIN_W-1:0] G_MIN = 16'sh8000;

    typedef struct {
        logic signed [Q_W-1:0] sample;
        logic                  clipped;
    } t_sample;

    // one row of the directed part; a typed row carries its own expected sample
    typedef struct {
        logic                     req;
        logic [IDX_W-1:0]         idx;
        logic signed [Q_W-1:0]    k;
        logic signed [Q_W-1:0]    prev;
        logic signed [GAIN_W-1:0] gain;
        logic                     typed;
        t_sample                  res;
    } t_row;

    // kinds of random phrase
    typedef enum {PH_SINE, PH_EXTREME, PH_NOISE, PH_SILENCE} t_phrase;

    // clock, reset and block ports
    logic                     i_clk;
    logic                     i_rst_n      = 1'b0;
    logic                     i_in_valid   = 1'b0;
    logic                     o_in_ready;
    logic                     i_req_type   = REQ_LOAD;
    logic [IDX_W-1:0]         i_osc_index  = '0;
    logic signed [Q_W-1:0]    i_coeff_k    = '0;
    logic signed [Q_W-1:0]    i_init_prev  = '0;
    logic signed [GAIN_W-1:0] i_gain_value = '0;
    logic                     o_out_valid;
    logic                     i_out_ready  = 1'b1;
    logic signed [Q_W-1:0]    o_sample;
    logic                     o_clipped;

    // bank model state: one word per oscillator
    logic signed [Q_W-1:0]    bank_k    [NUM_OSC];
    logic signed [Q_W-1:0]    bank_prev [NUM_OSC];
    logic signed [Q_W-1:0]    bank_cur  [NUM_OSC];
    logic signed [GAIN_W-1:0] bank_gain [NUM_OSC];

    t_sample pending_samples [$];   // samples owed by accepted ticks, oldest first
    t_row    dir_rows [$];
    int      mismatch_count = 0;
    int      items_sent     = 0;
    int      quiet_cycles   = 0;
    int      ready_cnt      = 0;
    bit      calm           = 1'b0;

    recursive_sine_oscillator_bank_top #(
        .NUM_OSC(NUM_OSC)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_req_type  (i_req_type),
        .i_osc_index (i_osc_index),
        .i_coeff_k   (i_coeff_k),
        .i_init_prev (i_init_prev),
        .i_gain_value(i_gain_value),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_sample    (o_sample),
        .o_clipped   (o_clipped)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // clamp to the q2.22 range, flag when the value moved
    function automatic logic signed [Q_W-1:0] clamp_q(input longint v, inout logic hit);
        if (v > Q_MAX) begin
            hit = 1'b1;
            return K_MAX;
        end
        if (v < Q_MIN) begin
            hit = 1'b1;
            return K_MIN;
        end
        return v[Q_W-1:0];
    endfunction

    // one sample tick of the whole bank: step every oscillator, sum the gained outputs
    function automatic t_sample bank_tick();
        longint  prod;
        longint  step;
        longint  acc;
        logic    hit;
        logic    osc_hit;
        t_sample r;
        acc     = 0;
        hit     = 1'b0;
        osc_hit = 1'b0;
        for (int i = 0; i < NUM_OSC; i++) begin
            // k*cur is q4.44, round half up back to q2.22, then subtract prev
            prod = longint'(bank_k[i]) * longint'(bank_cur[i]);
            step = ((prod + (64'sd1 <<< (ROUND_Q - 1))) >>> ROUND_Q) - longint'(bank_prev[i]);
            bank_prev[i] = bank_cur[i];
            bank_cur[i]  = clamp_q(step, osc_hit);
            // gain*out is q3.37, rounded half up to q3.22 and summed exactly
            prod = longint'(bank_gain[i]) * longint'(bank_cur[i]);
            acc += (prod + (64'sd1 <<< (ROUND_G - 1))) >>> ROUND_G;
        end
        // floor divide by the bank size, then saturate
        r.sample  = clamp_q(acc >>> NORM_SH, hit);
        r.clipped = hit;
        return r;
    endfunction

    // present one beat, hold it until taken, then update the bank model
    task automatic send_beat(input logic req, input logic [IDX_W-1:0] idx,
                             input logic signed [Q_W-1:0] k,
                             input logic signed [Q_W-1:0] prev,
                             input logic signed [GAIN_W-1:0] gain,
                             input logic typed, input t_sample typed_res);
        t_sample want;
        // random sender gap before this beat
        if (!calm && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_req_type   <= req;
        i_osc_index  <= idx;
        i_coeff_k    <= k;
        i_init_prev  <= prev;
        i_gain_value <= gain;
        do @(posedge i_clk); while (!o_in_ready);
        if (req == REQ_TICK) begin
            want = bank_tick();
            pending_samples.push_back(typed ? typed_res : want);
        end else if (idx < NUM_OSC) begin
            bank_k[idx]    = k;
            bank_prev[idx] = prev;
            bank_cur[idx]  = '0;
            bank_gain[idx] = gain;
        end
        items_sent++;
        calm = (items_sent >= N_ITEMS - CALM_ITEMS);
    endtask

    // tick with junk in the ignored fields
    task automatic send_tick();
        t_sample none;
        none = '{sample: '0, clipped: 1'b0};
        send_beat(REQ_TICK, IDX_W'($urandom), Q_W'($urandom), Q_W'($urandom),
                  GAIN_W'($urandom), 1'b0, none);
    endtask

    task automatic send_load(input logic [IDX_W-1:0] idx, input logic signed [Q_W-1:0] k,
                             input logic signed [Q_W-1:0] prev,
                             input logic signed [GAIN_W-1:0] gain);
        t_sample none;
        none = '{sample: '0, clipped: 1'b0};
        send_beat(REQ_LOAD, idx, k, prev, gain, 1'b0, none);
    endtask

    // stop sending until every owed sample has come back
    task automatic drain_wait();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_samples.size() != 0);
    endtask

    task automatic add_row(input logic req, input logic [IDX_W-1:0] idx,
                           input logic signed [Q_W-1:0] k, input logic signed [Q_W-1:0] prev,
                           input logic signed [GAIN_W-1:0] gain, input logic typed);
        t_row r;
        r.req   = req;
        r.idx   = idx;
        r.k     = k;
        r.prev  = prev;
        r.gain  = gain;
        r.typed = typed;
        // every typed row here is a silent bank
        r.res   = '{sample: '0, clipped: 1'b0};
        dir_rows.push_back(r);
    endtask

    function automatic logic signed [Q_W-1:0] pick_q();
        case ($urandom_range(0, 7))
            0: return K_MIN;
            1: return K_MIN + 24'sd1;
            2: return -24'sd1;
            3: return 24'sd0;
            4: return 24'sd1;
            5: return K_MAX - 24'sd1;
            6: return K_MAX;
            default: return Q_W'($urandom);
        endcase
    endfunction

    function automatic logic signed [GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 5))
            0: return G_MIN;
            1: return -16'sd1;
            2: return 16'sd0;
            3: return 16'sd1;
            4: return G_MAX;
            default: return GAIN_W'($urandom);
        endcase
    endfunction

    // sample side: random ready stalls between longer ready stretches
    always @(posedge i_clk) begin
        if (calm) begin
            i_out_ready <= 1'b1;
        end else if (ready_cnt != 0) begin
            ready_cnt <= ready_cnt - 1;
        end else if (i_out_ready && $urandom_range(0, 2) == 0) begin
            i_out_ready <= 1'b0;
            ready_cnt   <= $urandom_range(0, 12);
        end else begin
            i_out_ready <= 1'b1;
            ready_cnt   <= $urandom_range(0, 40);
        end
    end

    // sample checker and watchdog
    always @(posedge i_clk) begin
        t_sample want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_samples.size() == 0) begin
                $error("sample beat with no tick pending: sample %0d clipped %0d",
                       o_sample, o_clipped);
                mismatch_count++;
            end else begin
                want = pending_samples.pop_front();
                if (o_sample !== want.sample) begin
                    $error("sample mismatch: expected %0d, actual %0d", want.sample, o_sample);
                    mismatch_count++;
                end
                if (o_clipped !== want.clipped) begin
                    $error("clipped mismatch: expected %0d, actual %0d",
                           want.clipped, o_clipped);
                    mismatch_count++;
                end
            end
        end
        // a stuck handshake on both sides ends the run
        if (i_rst_n && ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // stimulus
    initial begin
        t_phrase                  kind;
        int                       n;
        int                       roll;
        logic [IDX_W-1:0]         idx;
        logic signed [Q_W-1:0]    k;
        logic signed [Q_W-1:0]    prev;
        real                      w;
        real                      kr;
        bit                       clip_done;
        clip_done = 1'b0;

        // model starts silent, like the swept store
        for (int i = 0; i < NUM_OSC; i++) begin
            bank_k[i]    = '0;
            bank_prev[i] = '0;
            bank_cur[i]  = '0;
            bank_gain[i] = '0;
        end

        // directed rows: silence after reset, field extremes, a clean sine,
        // reloads clearing the bank back to silence
        add_row(REQ_TICK, 7'h00, 24'sd0, 24'sd0, 16'sd0, 1'b1);
        add_row(REQ_LOAD, 7'h7F, K_MAX, K_MIN, G_MAX, 1'b0);
        add_row(REQ_LOAD, 7'h00, K_MIN, K_MAX, G_MIN, 1'b0);
        add_row(REQ_LOAD, 7'h40, 24'sd0, -24'sd1, 16'sd1, 1'b0);
        add_row(REQ_TICK, 7'h2A, 24'sd0, 24'sd0, 16'sd0, 1'b0);
        add_row(REQ_TICK, 7'h55, K_MAX, K_MIN, G_MIN, 1'b0);
        add_row(REQ_TICK, 7'h7F, K_MIN, K_MAX, G_MAX, 1'b0);
        add_row(REQ_LOAD, 7'h7F, 24'sd0, 24'sd0, 16'sd0, 1'b0);
        add_row(REQ_LOAD, 7'h00, 24'sd0, 24'sd0, 16'sd0, 1'b0);
        add_row(REQ_LOAD, 7'h40, 24'sd0, 24'sd0, 16'sd0, 1'b0);
        // tick fields are ignored, so junk in them must not matter
        add_row(REQ_TICK, 7'h7F, K_MIN, K_MAX, G_MIN, 1'b1);
        // eighth-rate sine: k = 2cos(pi/4), prev = -sin(pi/4)
        add_row(REQ_LOAD, 7'h01, 24'sd5931642, -24'sd2965821, G_MAX, 1'b0);
        add_row(REQ_LOAD, 7'h02, -24'sd1, 24'sd1, -16'sd1, 1'b0);
        add_row(REQ_TICK, 7'h00, 24'sd0, 24'sd0, 16'sd0, 1'b0);
        add_row(REQ_TICK, 7'h00, 24'sd0, 24'sd0, 16'sd0, 1'b0);
        add_row(REQ_TICK, 7'h00, 24'sd0, 24'sd0, 16'sd0, 1'b0);
        add_row(REQ_LOAD, 7'h03, 24'sd0, K_MIN, 16'sd16384, 1'b0);
        add_row(REQ_TICK, 7'h00, 24'sd0, 24'sd0, 16'sd0, 1'b0);
        add_row(REQ_LOAD, 7'h01, 24'sd0, 24'sd0, 16'sd0, 1'b0);
        add_row(REQ_LOAD, 7'h02, 24'sd0, 24'sd0, 16'sd0, 1'b0);
        add_row(REQ_LOAD, 7'h03, 24'sd0, 24'sd0, 16'sd0, 1'b0);
        add_row(REQ_TICK, 7'h33, K_MAX, K_MAX, G_MAX, 1'b1);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r]) begin
            send_beat(dir_rows[r].req, dir_rows[r].idx, dir_rows[r].k, dir_rows[r].prev,
                      dir_rows[r].gain, dir_rows[r].typed, dir_rows[r].res);
        end
        drain_wait();

        // random phrases: mostly reloads of a few oscillators followed by ticks
        while (items_sent < N_ITEMS) begin
            if (!clip_done && items_sent >= 600) begin
                // whole bank at k max, prev max, gain min: the second tick drives
                // every output to the negative rail and the sum past the top
                for (int o = 0; o < NUM_OSC; o++) begin
                    send_load(IDX_W'(o), K_MAX, K_MAX, G_MIN);
                end
                repeat (3) send_tick();
                // and back to silence
                for (int o = 0; o < NUM_OSC; o++) begin
                    send_load(IDX_W'(o), 24'sd0, 24'sd0, 16'sd0);
                end
                send_tick();
                clip_done = 1'b1;
                continue;
            end

            roll = $urandom_range(0, 9);
            if (roll < 5) begin
                kind = PH_SINE;
            end else if (roll < 7) begin
                kind = PH_EXTREME;
            end else if (roll < 9) begin
                kind = PH_NOISE;
            end else begin
                kind = PH_SILENCE;
            end

            case (kind)
                PH_SINE: begin
                    n = $urandom_range(1, 12);
                    repeat (n) begin
                        // k = 2cos(w) saturated at the top, prev = -sin(w)
                        w  = $urandom_range(1, 65535) * (3.14159265358979 / 65536.0);
                        kr = 2.0 * $cos(w) * 4194304.0;
                        k  = (kr >= 8388607.0) ? K_MAX : Q_W'(longint'(kr));
                        prev = Q_W'(longint'(-$sin(w) * 4194304.0));
                        send_load(IDX_W'($urandom), k, prev, GAIN_W'($urandom));
                    end
                    repeat ($urandom_range(1, 8)) send_tick();
                end
                PH_EXTREME: begin
                    repeat ($urandom_range(1, 8)) begin
                        send_load(IDX_W'($urandom), pick_q(), pick_q(), pick_gain());
                    end
                    repeat ($urandom_range(1, 4)) send_tick();
                end
                PH_NOISE: begin
                    repeat ($urandom_range(1, 10)) begin
                        if ($urandom_range(0, 1) == 1) begin
                            send_tick();
                        end else begin
                            send_load(IDX_W'($urandom), Q_W'($urandom), Q_W'($urandom),
                                      GAIN_W'($urandom));
                        end
                    end
                end
                PH_SILENCE: begin
                    // mute a few oscillators, with zero gain or zero history
                    repeat ($urandom_range(1, 6)) begin
                        idx = IDX_W'($urandom);
                        if ($urandom_range(0, 1) == 1) begin
                            send_load(idx, Q_W'($urandom), Q_W'($urandom), 16'sd0);
                        end else begin
                            send_load(idx, Q_W'($urandom), 24'sd0, GAIN_W'($urandom));
                        end
                    end
                    repeat ($urandom_range(1, 3)) send_tick();
                end
                default: ;
            endcase

            // now and then hold off until the bank has caught up
            if (!calm && $urandom_range(0, 19) == 0) begin
                drain_wait();
            end
        end

        // wait out every owed sample, then watch a while for strays
        drain_wait();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
